// File: hw/rtl/cer_pkg.sv
// Shared types, constants and the 16.16 multiply for the camera rotation block.
package cer_pkg;

   localparam int DATA_W    = 32;
   localparam int TRIG_W    = 18;
   localparam int CSR_W     = 36;
   localparam int CSR_IDX_W = 3;
   localparam int FRAC_BITS = 16;
   localparam int PROD_W    = DATA_W + TRIG_W;
   localparam int STAGES    = 7;

   localparam logic [DATA_W-1:0] CAMERA_RESET = '0;
   localparam logic [CSR_W-1:0]  TRIG_RESET   = CSR_W'(65536);

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_CAMERA_X     = 3'd0,
      REG_CAMERA_Y     = 3'd1,
      REG_CAMERA_Z     = 3'd2,
      REG_TRIG_ABOUT_X = 3'd3,
      REG_TRIG_ABOUT_Y = 3'd4,
      REG_TRIG_ABOUT_Z = 3'd5
   } reg_index_type;

   typedef logic signed [DATA_W-1:0] fix_type;
   typedef logic signed [TRIG_W-1:0] trig_type;

   // Decoded configuration as seen by the datapath
   typedef struct packed {
      fix_type  cam_x;
      fix_type  cam_y;
      fix_type  cam_z;
      trig_type sin_x;
      trig_type cos_x;
      trig_type sin_y;
      trig_type cos_y;
      trig_type sin_z;
      trig_type cos_z;
   } cfg_type;

   // 16.16 product: bits 47:16 of the exact signed product
   function automatic fix_type fmul(input trig_type a, input fix_type b);
      logic signed [PROD_W-1:0] p;
      p = PROD_W'(a) * PROD_W'(b);
      return p[FRAC_BITS+DATA_W-1:FRAC_BITS];
   endfunction

endpackage

// File: hw/rtl/cer_if.sv
// Channel interfaces: point request, view response and register write.
interface cer_req_if;
   logic           valid;
   logic           ready;
   cer_pkg::fix_type point_x;
   cer_pkg::fix_type point_y;
   cer_pkg::fix_type point_z;
   modport source (output valid, output point_x, output point_y, output point_z, input ready);
   modport sink   (input valid, input point_x, input point_y, input point_z, output ready);
endinterface

interface cer_rsp_if;
   logic           valid;
   logic           ready;
   cer_pkg::fix_type view_x;
   cer_pkg::fix_type view_y;
   cer_pkg::fix_type view_z;
   modport source (output valid, output view_x, output view_y, output view_z, input ready);
   modport sink   (input valid, input view_x, input view_y, input view_z, output ready);
endinterface

interface cer_csr_if;
   logic                             valid;
   logic                             ready;
   logic [cer_pkg::CSR_IDX_W-1:0]    index;
   logic [cer_pkg::CSR_W-1:0]        data;
   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

// File: hw/rtl/cer_csr.sv
// Configuration register file: camera position and three sine/cosine pairs.
module cer_csr (
   input  logic              clock,
   input  logic              reset,
   cer_csr_if.sink           csr,
   output cer_pkg::cfg_type  cfg
);

   logic [cer_pkg::DATA_W-1:0] cam_x_ff, cam_y_ff, cam_z_ff;
   logic [cer_pkg::CSR_W-1:0]  trig_x_ff, trig_y_ff, trig_z_ff;

   assign csr.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cam_x_ff  <= cer_pkg::CAMERA_RESET;
         cam_y_ff  <= cer_pkg::CAMERA_RESET;
         cam_z_ff  <= cer_pkg::CAMERA_RESET;
         trig_x_ff <= cer_pkg::TRIG_RESET;
         trig_y_ff <= cer_pkg::TRIG_RESET;
         trig_z_ff <= cer_pkg::TRIG_RESET;
      end else if (csr.valid) begin
         unique case (csr.index)
            cer_pkg::REG_CAMERA_X:     cam_x_ff  <= csr.data[cer_pkg::DATA_W-1:0];
            cer_pkg::REG_CAMERA_Y:     cam_y_ff  <= csr.data[cer_pkg::DATA_W-1:0];
            cer_pkg::REG_CAMERA_Z:     cam_z_ff  <= csr.data[cer_pkg::DATA_W-1:0];
            cer_pkg::REG_TRIG_ABOUT_X: trig_x_ff <= csr.data;
            cer_pkg::REG_TRIG_ABOUT_Y: trig_y_ff <= csr.data;
            cer_pkg::REG_TRIG_ABOUT_Z: trig_z_ff <= csr.data;
            default: ;  // unmapped index: write dropped
         endcase
      end
   end

   // sine in the upper half, cosine in the lower
   always_comb begin
      cfg.cam_x = cam_x_ff;
      cfg.cam_y = cam_y_ff;
      cfg.cam_z = cam_z_ff;
      cfg.sin_x = trig_x_ff[2*cer_pkg::TRIG_W-1:cer_pkg::TRIG_W];
      cfg.cos_x = trig_x_ff[cer_pkg::TRIG_W-1:0];
      cfg.sin_y = trig_y_ff[2*cer_pkg::TRIG_W-1:cer_pkg::TRIG_W];
      cfg.cos_y = trig_y_ff[cer_pkg::TRIG_W-1:0];
      cfg.sin_z = trig_z_ff[2*cer_pkg::TRIG_W-1:cer_pkg::TRIG_W];
      cfg.cos_z = trig_z_ff[cer_pkg::TRIG_W-1:0];
   end

endmodule

// File: hw/rtl/camera_euler_rotate_point.sv
// Top level: world point to camera space, offset then z, y, x Euler rotation.
//
//   channel | dir | transaction payload                 | handshake
//   req     | in  | point_x, point_y, point_z (16.16)    | valid/ready
//   rsp     | out | view_x, view_y, view_z (16.16)       | valid/ready
//   csr     | in  | index (3b), data (36b)               | valid/ready, ready always high
//
// Seven register stages; one transaction is taken per cycle unless every stage
// is full behind a blocked response, as ready passes back combinationally from
// the response port.
// Synchronous active-high reset clears the stage valid bits and loads the
// register defaults (camera at origin, all angles zero).
// Each stage holds while its successor is full and blocked, so bubbles are
// squeezed out and a stalled response holds without loss or repeat.
module camera_euler_rotate_point (
   input  logic     clock,
   input  logic     reset,
   cer_req_if.sink  req,
   cer_rsp_if.source rsp,
   cer_csr_if.sink  csr
);

   localparam int N = cer_pkg::STAGES;

   cer_pkg::cfg_type cfg;

   cer_csr u_csr (
      .clock (clock),
      .reset (reset),
      .csr   (csr),
      .cfg   (cfg)
   );

   // ---------------------------------------------------------------
   // Stage control: valid bit per stage, ready ripples back from rsp
   // ---------------------------------------------------------------
   logic [N-1:0] vld_ff, vld_in;
   logic [N:0]   rdy;     // rdy[k]: stage k may load; rdy[N] is the sink
   logic [N-1:0] vld_up;  // valid offered to stage k

   always_comb begin
      rdy[N] = rsp.ready;
      for (int k = N - 1; k >= 0; k--) begin
         rdy[k] = !vld_ff[k] || rdy[k+1];
      end
      vld_up[0] = req.valid;
      for (int k = 1; k < N; k++) begin
         vld_up[k] = vld_ff[k-1];
      end
      for (int k = 0; k < N; k++) begin
         vld_in[k] = rdy[k] ? vld_up[k] : vld_ff[k];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   assign req.ready = rdy[0];

   // ---------------------------------------------------------------
   // Datapath
   // ---------------------------------------------------------------
   // s1: offset from camera, wraps
   cer_pkg::fix_type ox_ff, oy_ff, oz_ff;
   // s2: first products
   cer_pkg::fix_type szoy_ff, czox_ff, czoy_ff, szox_ff, cyoz2_ff, syoz2_ff;
   // s3: z rotation
   cer_pkg::fix_type zra_ff, zrb_ff, cyoz3_ff, syoz3_ff;
   // s4: products on the z-rotated pair
   cer_pkg::fix_type syzra_ff, cyzra_ff, sxzrb_ff, cxzrb4_ff, cyoz4_ff, syoz4_ff;
   // s5: y rotation, view_x done
   cer_pkg::fix_type yr_ff, vx5_ff, cxzrb5_ff, sxzrb5_ff;
   // s6: x rotation products
   cer_pkg::fix_type sxyr_ff, cxyr_ff, vx6_ff, cxzrb6_ff, sxzrb6_ff;
   // s7: output register
   cer_pkg::fix_type vx7_ff, vy7_ff, vz7_ff;

   always_ff @(posedge clock) begin
      if (rdy[0]) begin
         ox_ff <= req.point_x - cfg.cam_x;
         oy_ff <= req.point_y - cfg.cam_y;
         oz_ff <= req.point_z - cfg.cam_z;
      end
      if (rdy[1]) begin
         szoy_ff  <= cer_pkg::fmul(cfg.sin_z, oy_ff);
         czox_ff  <= cer_pkg::fmul(cfg.cos_z, ox_ff);
         czoy_ff  <= cer_pkg::fmul(cfg.cos_z, oy_ff);
         szox_ff  <= cer_pkg::fmul(cfg.sin_z, ox_ff);
         cyoz2_ff <= cer_pkg::fmul(cfg.cos_y, oz_ff);
         syoz2_ff <= cer_pkg::fmul(cfg.sin_y, oz_ff);
      end
      if (rdy[2]) begin
         zra_ff   <= szoy_ff + czox_ff;
         zrb_ff   <= czoy_ff - szox_ff;
         cyoz3_ff <= cyoz2_ff;
         syoz3_ff <= syoz2_ff;
      end
      if (rdy[3]) begin
         syzra_ff  <= cer_pkg::fmul(cfg.sin_y, zra_ff);
         cyzra_ff  <= cer_pkg::fmul(cfg.cos_y, zra_ff);
         sxzrb_ff  <= cer_pkg::fmul(cfg.sin_x, zrb_ff);
         cxzrb4_ff <= cer_pkg::fmul(cfg.cos_x, zrb_ff);
         cyoz4_ff  <= cyoz3_ff;
         syoz4_ff  <= syoz3_ff;
      end
      if (rdy[4]) begin
         yr_ff     <= cyoz4_ff + syzra_ff;
         vx5_ff    <= cyzra_ff - syoz4_ff;
         cxzrb5_ff <= cxzrb4_ff;
         sxzrb5_ff <= sxzrb_ff;
      end
      if (rdy[5]) begin
         sxyr_ff   <= cer_pkg::fmul(cfg.sin_x, yr_ff);
         cxyr_ff   <= cer_pkg::fmul(cfg.cos_x, yr_ff);
         vx6_ff    <= vx5_ff;
         cxzrb6_ff <= cxzrb5_ff;
         sxzrb6_ff <= sxzrb5_ff;
      end
      if (rdy[6]) begin
         vx7_ff <= vx6_ff;
         vy7_ff <= sxyr_ff + cxzrb6_ff;
         vz7_ff <= cxyr_ff - sxzrb6_ff;
      end
   end

   assign rsp.valid  = vld_ff[N-1];
   assign rsp.view_x = vx7_ff;
   assign rsp.view_y = vy7_ff;
   assign rsp.view_z = vz7_ff;

endmodule

// File: hw/rtl/cer_checker.sv
// Port-level checks for the camera rotation block, bound to the top level.
module cer_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_ready,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input cer_pkg::fix_type view_x,
   input cer_pkg::fix_type view_y,
   input cer_pkg::fix_type view_z
);

   // reset empties the pipeline
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid after reset");

   // input only back-pressured when every stage is full behind a blocked output
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> (rsp_valid && !rsp_ready))
      else $error("request stalled with output free");

   // blocked response holds its transaction
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=>
         (rsp_valid && $stable(view_x) && $stable(view_y) && $stable(view_z)))
      else $error("stalled response changed");

endmodule

bind camera_euler_rotate_point cer_checker u_cer_checker (
   .clock     (clock),
   .reset     (reset),
   .req_ready (req.ready),
   .rsp_valid (rsp.valid),
   .rsp_ready (rsp.ready),
   .view_x    (rsp.view_x),
   .view_y    (rsp.view_y),
   .view_z    (rsp.view_z)
);
